@@ rtl/fpli_pkg.sv @@
// Shared types and constants for the frame phase linear interpolator.
// No dependencies; every other file imports this package.
package fpli_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int FRAME_BITS    = 32;
    localparam int INTERVAL_BITS = 8;
    localparam int PERIOD_BITS   = 16;
    localparam int PHASE_BITS    = 8;
    localparam int CMD_BITS      = 2;

    localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_BLEND   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]          command;
        logic signed [VALUE_BITS-1:0] value_old;
        logic signed [VALUE_BITS-1:0] value_new;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] blended_value;
        logic [PERIOD_BITS-1:0]       period_count;
        logic [PHASE_BITS-1:0]        phase;
        logic                         should_update;
        logic                         about_to_update;
    } t_out_word;

endpackage

@@ rtl/frame_phase_linear_interpolator_top.sv @@
// Frame phase linear interpolator: one result word per command word
// (tick, interpolate, restart). Every command goes through the restoring
// divider, which produces one quotient bit per cycle for frame_count /
// interval and for the new-value weight; a new command is taken only after
// the previous result has been loaded into the output register. A finished
// result sits in the output register while the next command is taken; a
// result that finds the register still full waits in ST_OUT.
// Depends on fpli_pkg, fpli_divider and fpli_blend.
module frame_phase_linear_interpolator_top #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fpli_pkg::INTERVAL_BITS-1:0]   i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  fpli_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output fpli_pkg::t_out_word                  o_out_word
);
    import fpli_pkg::*;

    localparam int W  = WEIGHT_FRAC_BITS;
    localparam int QW = PERIOD_BITS + W;
    localparam logic [W:0] FULL_WEIGHT = {1'b1, {W{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state                   r_state,    n_state;
    logic [INTERVAL_BITS-1:0] r_interval, n_interval;
    logic [FRAME_BITS-1:0]    r_fc,       n_fc;
    logic [PHASE_BITS-1:0]    r_phase,    n_phase;
    logic [W:0]               r_weight,   n_weight;
    logic [PERIOD_BITS-1:0]   r_period,   n_period;
    logic [CMD_BITS-1:0]      r_cmd,      n_cmd;
    logic                     r_out_valid, n_out_valid;
    t_out_word                r_out_word;

    logic                     w_accept;
    logic                     w_load_out;
    logic [FRAME_BITS-1:0]    w_fc_next;
    logic                     w_div_done;
    logic [QW-1:0]            w_quot;
    logic [PHASE_BITS-1:0]    w_rem;
    logic signed [VALUE_BITS-1:0] w_blend;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign w_fc_next  = (i_in_word.command == CMD_TICK) ? r_fc + 1'b1 : r_fc;

    fpli_divider #(.FRAC_BITS(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_fc_next),
        .i_divisor  (r_interval),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    fpli_blend #(.FRAC_BITS(W)) u_blend (
        .i_clk       (i_clk),
        .i_start     (w_accept),
        .i_value_old (i_in_word.value_old),
        .i_value_new (i_in_word.value_new),
        .i_weight    (r_weight),
        .o_blend     (w_blend)
    );

    always_comb begin
        n_state     = r_state;
        n_interval  = r_interval;
        n_fc        = r_fc;
        n_phase     = r_phase;
        n_weight    = r_weight;
        n_period    = r_period;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // interval write acts as a restart; zero is stored as one
        if (i_cfg_we) begin
            n_interval = (i_cfg_wdata == '0) ? INTERVAL_BITS'(1) : i_cfg_wdata;
            n_phase    = '0;
            n_weight   = (i_cfg_wdata > INTERVAL_BITS'(1)) ? '0 : FULL_WEIGHT;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_in_word.command;
                    n_fc    = w_fc_next;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_period = w_quot[QW-1:W];
                    if (r_cmd == CMD_TICK) begin
                        if (r_interval > INTERVAL_BITS'(1)) begin
                            n_phase  = w_rem;
                            n_weight = {1'b0, w_quot[W-1:0]};
                        end else begin
                            n_phase  = '0;
                            n_weight = FULL_WEIGHT;
                        end
                    end else if (r_cmd == CMD_RESTART) begin
                        n_phase  = '0;
                        n_weight = (r_interval > INTERVAL_BITS'(1)) ? '0 : FULL_WEIGHT;
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_interval  <= INTERVAL_BITS'(1);
            r_fc        <= '0;
            r_phase     <= '0;
            r_weight    <= FULL_WEIGHT;
            r_period    <= '0;
            r_cmd       <= CMD_TICK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_interval  <= n_interval;
            r_fc        <= n_fc;
            r_phase     <= n_phase;
            r_weight    <= n_weight;
            r_period    <= n_period;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_word.blended_value   <= (r_cmd == CMD_BLEND) ? w_blend : '0;
            r_out_word.period_count    <= r_period;
            r_out_word.phase           <= r_phase;
            r_out_word.should_update   <= (r_phase == '0);
            r_out_word.about_to_update <= (r_phase == r_interval - 1'b1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_phase_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < r_interval)
        else $error("phase not below interval");

    a_unit_interval_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_interval == INTERVAL_BITS'(1)) |-> (r_weight == FULL_WEIGHT))
        else $error("interval of one without full weight");

    a_weight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weight <= FULL_WEIGHT)
        else $error("weight above full");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("ready right after accepting a word");

endmodule

@@ rtl/fpli_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by every command.
// Divides {dividend, FRAC_BITS zeros} by the interval; depends on fpli_pkg.
module fpli_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [fpli_pkg::FRAME_BITS-1:0]              i_dividend,
    input  logic [fpli_pkg::INTERVAL_BITS-1:0]           i_divisor,
    output logic                                         o_done,
    output logic [fpli_pkg::PERIOD_BITS+FRAC_BITS-1:0]   o_quot,
    output logic [fpli_pkg::PHASE_BITS-1:0]              o_rem
);
    import fpli_pkg::*;

    localparam int STEPS = FRAME_BITS + FRAC_BITS;
    localparam int CW    = $clog2(STEPS);
    localparam int QW    = PERIOD_BITS + FRAC_BITS;

    logic                     r_busy;
    logic                     r_done;
    logic [CW-1:0]            r_cnt;
    logic [FRAME_BITS-1:0]    r_dvd;
    logic [INTERVAL_BITS-1:0] r_rem;
    logic [QW-1:0]            r_quot;
    logic [PHASE_BITS-1:0]    r_phase;

    logic [INTERVAL_BITS:0]   w_part;
    logic [INTERVAL_BITS:0]   w_diff;
    logic                     w_fit;
    logic [INTERVAL_BITS-1:0] n_rem;

    // partial remainder stays below the divisor, so part < 2 * divisor
    always_comb begin
        w_part = {r_rem, r_dvd[FRAME_BITS-1]};
        w_diff = w_part - {1'b0, i_divisor};
        w_fit  = (w_part >= {1'b0, i_divisor});
        n_rem  = w_fit ? w_diff[INTERVAL_BITS-1:0] : w_part[INTERVAL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[FRAME_BITS-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[QW-2:0], w_fit};
            // remainder after the integer bits is the frame phase
            if (r_cnt == CW'(FRAME_BITS - 1)) begin
                r_phase <= n_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_phase;

endmodule

@@ rtl/fpli_blend.sv @@
// Weighted blend old + ((new - old) * w >>> FRAC_BITS), wrapped to VALUE_BITS.
// Operands latch on start and the product is registered from them; the final sum is combinational. Depends on fpli_pkg.
module fpli_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_start,
    input  logic signed [fpli_pkg::VALUE_BITS-1:0] i_value_old,
    input  logic signed [fpli_pkg::VALUE_BITS-1:0] i_value_new,
    input  logic [FRAC_BITS:0]                  i_weight,
    output logic signed [fpli_pkg::VALUE_BITS-1:0] o_blend
);
    import fpli_pkg::*;

    localparam int PW = VALUE_BITS + FRAC_BITS + 3;

    logic signed [VALUE_BITS-1:0] r_base;
    logic signed [VALUE_BITS:0]   r_diff;
    logic        [FRAC_BITS:0]    r_weight;
    logic signed [PW-1:0]         r_prod;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_base   <= i_value_old;
            r_diff   <= {i_value_new[VALUE_BITS-1], i_value_new}
                      - {i_value_old[VALUE_BITS-1], i_value_old};
            r_weight <= i_weight;
        end
        r_prod <= PW'(r_diff * $signed({1'b0, r_weight}));
    end

    // old * FULL is an exact multiple, so the floor only acts on the delta term
    assign o_blend = r_base + r_prod[FRAC_BITS+VALUE_BITS-1:FRAC_BITS];

endmodule

@@ bench/tb.sv @@
// Self-checking bench for frame_phase_linear_interpolator_top.
// Directed table, then random commands over many interval settings; typed
// rows use a hand result, others a predictor here. Needs fpli_pkg, RTL only.
module tb;
    import fpli_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int                  FRAC       = 16;
    localparam logic [FRAC:0]       FULL_W     = 17'h10000;
    localparam int                  LIMIT      = 1_000_000;
    localparam int                  RAND_ITEMS = 1550;
    localparam int                  PHASES     = 12;
    localparam int                  LONG_HOLD  = 700;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [INTERVAL_BITS-1:0]  cfg;
        t_in_word                  w;
        logic                      typed;
        t_out_word                 res;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    // rows marked typed carry a result that follows from reset state by hand
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
          '{32'h7FFF_FFFF, 16'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
          '{32'h8000_0000, 16'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
          '{32'hFFFF_FFFF, 16'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_WORD, 8'd0, '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0, 16'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 16'd1, 8'd0, 1'b1, 1'b1}},
        '{ROW_WORD, 8'd0, '{CMD_RESTART, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 16'd1, 8'd0, 1'b1, 1'b1}},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'hFFFF_FFFF, 32'h0}, 1'b1,
          '{32'h0, 16'd2, 8'd0, 1'b1, 1'b1}},
        // zero interval is stored as one
        '{ROW_CFG, 8'd0, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 16'd3, 8'd0, 1'b1, 1'b1}},
        '{ROW_CFG, 8'd255, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        // restart leaves zero weight on the new value
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
          '{32'h8000_0000, 16'd0, 8'd0, 1'b1, 1'b0}},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_RESTART, 32'h0, 32'h0}, 1'b1,
          '{32'h0, 16'd0, 8'd0, 1'b1, 1'b0}},
        '{ROW_CFG, 8'd2, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'hFFFF_FFFF, 32'h0000_0001}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        '{ROW_CFG, 8'd3, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_TICK, 32'h0, 32'h0}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_BLEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b0, '0},
        '{ROW_WORD, 8'd0, '{CMD_RESTART, 32'h0, 32'h0}, 1'b0, '0}
    };

    localparam logic [INTERVAL_BITS-1:0] PHASE_IVL [PHASES-2] = '{
        8'd255, 8'd2, 8'd1, 8'd254, 8'd7, 8'd0, 8'd128, 8'd3, 8'd60, 8'd16
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_word  out_word;

    frame_phase_linear_interpolator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [INTERVAL_BITS-1:0] ivl_m = 8'd1;
    logic [FRAME_BITS-1:0]    frames_m = '0;
    logic [PHASE_BITS-1:0]    phase_m = '0;
    logic [FRAC:0]            weight_m = FULL_W;

    t_out_word pending_results [$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        send_quiet = 1'b0;
    bit        recv_quiet = 1'b0;
    bit        hold_req = 1'b0;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void restart_phase_m();
        phase_m  = '0;
        weight_m = (ivl_m > 8'd1) ? '0 : FULL_W;
    endfunction

    function automatic t_out_word predict_interp(t_in_word w);
        t_out_word r;
        longint    acc;
        r = '0;
        case (w.command)
            CMD_TICK: begin
                frames_m = frames_m + 1;
                if (ivl_m > 8'd1) begin
                    phase_m  = PHASE_BITS'(frames_m % ivl_m);
                    weight_m = (FRAC+1)'((64'(phase_m) << FRAC) / ivl_m);
                end else begin
                    phase_m  = '0;
                    weight_m = FULL_W;
                end
            end
            CMD_BLEND: begin
                acc = longint'(w.value_old) * (longint'(FULL_W) - longint'(weight_m))
                    + longint'(w.value_new) * longint'(weight_m);
                r.blended_value = VALUE_BITS'(acc >>> FRAC);
            end
            CMD_RESTART: restart_phase_m();
            default: ;
        endcase
        r.period_count    = PERIOD_BITS'(frames_m / ivl_m);
        r.phase           = phase_m;
        r.should_update   = (phase_m == '0);
        r.about_to_update = (phase_m == ivl_m - 8'd1);
        return r;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(t_in_word w, logic typed, t_out_word typed_res);
        int        gap;
        t_out_word res;
        gap = send_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word  = w;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        res = predict_interp(w);
        pending_results.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    // block must be idle here
    task automatic write_interval(logic [INTERVAL_BITS-1:0] v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        ivl_m  = (v == '0) ? 8'd1 : v;
        restart_phase_m();
    endtask

    task automatic check_word(t_out_word got);
        t_out_word exp_w;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word %h at cycle %0d", got, cycles);
            return;
        end
        exp_w = pending_results.pop_front();
        if (got.blended_value !== exp_w.blended_value
                || got.period_count !== exp_w.period_count
                || got.phase !== exp_w.phase
                || got.should_update !== exp_w.should_update
                || got.about_to_update !== exp_w.about_to_update) begin
            mismatches++;
            if (mismatches <= 10)
                $display("cycle %0d: exp blend %h per %0d ph %0d su %b atu %b, got %h %0d %0d %b %b",
                         cycles, exp_w.blended_value, exp_w.period_count, exp_w.phase,
                         exp_w.should_update, exp_w.about_to_update,
                         got.blended_value, got.period_count, got.phase,
                         got.should_update, got.about_to_update);
        end
    endtask

    // result side
    initial begin
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = recv_quiet ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            check_word(out_word);
            @(negedge clk);
        end
    end

    // command side
    initial begin
        t_in_word                 w;
        int                       pick;
        int                       per_phase;
        logic [INTERVAL_BITS-1:0] ivl;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TAB[i].kind == ROW_CFG) begin
                drain();
                write_interval(DIR_TAB[i].cfg);
            end else begin
                send_word(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].res);
            end
        end

        per_phase = RAND_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            ivl = (p < PHASES - 2) ? PHASE_IVL[p] : 8'($urandom_range(1, 255));
            drain();
            write_interval(ivl);
            for (int n = 0; n < per_phase; n++) begin
                if (n % 40 == 0) begin
                    send_quiet = ($urandom_range(0, 3) == 0);
                    recv_quiet = ($urandom_range(0, 3) == 0);
                end
                // stall the result side long enough to back up the input
                if (p == 1 && n == 20)
                    hold_req = 1'b1;
                if (p == 4 && n == per_phase / 2)
                    drain();
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    w.command = CMD_TICK;
                else if (pick < 85)
                    w.command = CMD_BLEND;
                else if (pick < 93)
                    w.command = CMD_RESTART;
                else
                    w.command = CMD_UNUSED;
                w.value_old = rand_q16();
                w.value_new = rand_q16();
                send_word(w, 1'b0, '0);
            end
        end

        drain();
        repeat (60) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
